// ===== src/rsst_pkg.sv =====
// Shared widths, codes, sequencer states and control bundle of the range-sum tree.
`default_nettype none

package rsst_pkg;

	// Fixed field widths.
	localparam int IDX_W = 10;
	localparam int VAL_W = 32;
	localparam int SUM_W = 42;

	// Default number of leaf elements.
	localparam int LEAVES_DEF = 1024;

	// Operation codes carried in the action field.
	localparam logic ACT_SET   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SET_LEAF,
		ST_SET_RD,
		ST_SET_WR,
		ST_Q_L,
		ST_Q_R,
		ST_RESULT
	} rsst_state_t;

	// Controls from the sequencer to the shared adder datapath.
	typedef struct packed {
		logic load_val;  // capture the sign-extended set value
		logic clr_acc;   // zero the accumulator
		logic acc_add;   // accumulate mode: acc plus read data
		logic add_a;     // read data on port A takes part in the add
		logic wr_sum;    // write data is the adder output
		logic wr_zero;   // write data is zero
		logic res_load;  // move the accumulator into the result register
	} rsst_ctrl_t;

endpackage

`default_nettype wire

// ===== src/rsst_if.sv =====
// Valid/ready channel interfaces for commands and query results.
`default_nettype none

interface rsst_in_if import rsst_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    action;
	logic [IDX_W-1:0]        element_index;
	logic signed [VAL_W-1:0] set_value;
	logic [IDX_W-1:0]        range_low;
	logic [IDX_W-1:0]        range_high;

	modport source (
		output valid, action, element_index, set_value, range_low, range_high,
		input  ready
	);
	modport sink (
		input  valid, action, element_index, set_value, range_low, range_high,
		output ready
	);
endinterface

interface rsst_out_if import rsst_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] range_sum;

	modport source (
		output valid, range_sum,
		input  ready
	);
	modport sink (
		input  valid, range_sum,
		output ready
	);
endinterface

`default_nettype wire

// ===== src/rsst_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module rsst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re_a,
	input  wire logic [AW-1:0]    raddr_a,
	output logic      [WIDTH-1:0] rdata_a,
	input  wire logic             re_b,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Two registered read ports; data holds while a port is not enabled.
	always_ff @(posedge clk) begin
		if (re_a) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

// ===== src/rsst_seq.sv =====
// Sequencer: clearing pass, update walk to the root and bottom-up range query walk.
`default_nettype none

module rsst_seq import rsst_pkg::*; #(
	parameter int LEAVES = LEAVES_DEF,
	localparam int AW = $clog2(2 * LEAVES)
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	rsst_in_if.sink         cmd,
	input  wire logic       res_ready,
	output logic            res_valid,
	output rsst_ctrl_t      ctrl,
	output logic            we,
	output logic [AW-1:0]   waddr,
	output logic            re_a,
	output logic [AW-1:0]   raddr_a,
	output logic            re_b,
	output logic [AW-1:0]   raddr_b
);

	// Node pointer widths: r may reach 2*LEAVES itself.
	localparam int NW = $clog2(2 * LEAVES + 1);
	localparam int XW = (NW > IDX_W) ? NW : IDX_W;
	localparam logic [XW-1:0] LEAVES_X = XW'(LEAVES);
	localparam logic [XW-1:0] LAST_X   = XW'(LEAVES - 1);
	localparam logic [AW-1:0] LAST_NODE = AW'(2 * LEAVES - 1);

	rsst_state_t   state_q, state_d;
	logic [AW-1:0] v_q, v_d;
	logic [NW-1:0] l_q, l_d;
	logic [NW-1:0] r_q, r_d;
	logic          add_a_q, add_a_d;
	logic          out_valid_q;

	logic [XW-1:0] idx_x;
	logic [XW-1:0] lo_x;
	logic [XW-1:0] hi_x;
	logic [XW-1:0] hi_c;
	logic          idx_ok;
	logic          q_empty;
	logic [NW-1:0] r_m;

	assign cmd.ready = (state_q == ST_IDLE);
	assign res_valid = out_valid_q;

	// Range checks on the incoming indices, with the high bound clamped to the last leaf.
	assign idx_x   = XW'(cmd.element_index);
	assign lo_x    = XW'(cmd.range_low);
	assign hi_x    = XW'(cmd.range_high);
	assign hi_c    = (hi_x >= LEAVES_X) ? LAST_X : hi_x;
	assign idx_ok  = (idx_x < LEAVES_X);
	assign q_empty = (lo_x >= LEAVES_X) || (lo_x > hi_c);

	// Right pointer after taking an odd right boundary node.
	assign r_m = r_q - NW'(r_q[0]);

	// State and pointer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			v_q     <= '0;
			l_q     <= '0;
			r_q     <= '0;
			add_a_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_q     <= v_d;
			l_q     <= l_d;
			r_q     <= r_d;
			add_a_q <= add_a_d;
		end
	end

	// Result slot: filled from the accumulator, emptied by a result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.res_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state, memory accesses and datapath controls.
	always_comb begin
		state_d    = state_q;
		v_d        = v_q;
		l_d        = l_q;
		r_d        = r_q;
		add_a_d    = add_a_q;
		ctrl       = '0;
		ctrl.add_a = add_a_q;
		we         = 1'b0;
		waddr      = v_q;
		re_a       = 1'b0;
		raddr_a    = l_q[AW-1:0];
		re_b       = 1'b0;
		raddr_b    = {v_q[AW-2:0], 1'b1};
		case (state_q)
			ST_CLEAR: begin
				// One node zeroed per cycle after reset.
				we           = 1'b1;
				ctrl.wr_zero = 1'b1;
				v_d          = v_q + AW'(1);
				if (v_q == LAST_NODE) begin
					v_d     = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd.valid) begin
					if (cmd.action == ACT_SET) begin
						// A set past the last leaf is dropped.
						if (idx_ok) begin
							ctrl.load_val = 1'b1;
							v_d           = AW'(idx_x + LEAVES_X);
							state_d       = ST_SET_LEAF;
						end
					end else begin
						ctrl.clr_acc = 1'b1;
						add_a_d      = 1'b0;
						if (q_empty) begin
							state_d = ST_RESULT;
						end else begin
							l_d     = NW'(lo_x + LEAVES_X);
							r_d     = NW'(hi_c + LEAVES_X + XW'(1));
							state_d = ST_Q_L;
						end
					end
				end
			end
			ST_SET_LEAF: begin
				we      = 1'b1;
				v_d     = v_q >> 1;
				state_d = ST_SET_RD;
			end
			ST_SET_RD: begin
				// Fetch both children of the current node, or stop past the root.
				if (v_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					re_a    = 1'b1;
					raddr_a = {v_q[AW-2:0], 1'b0};
					re_b    = 1'b1;
					state_d = ST_SET_WR;
				end
			end
			ST_SET_WR: begin
				we          = 1'b1;
				ctrl.wr_sum = 1'b1;
				v_d         = v_q >> 1;
				state_d     = ST_SET_RD;
			end
			ST_Q_L: begin
				// Fold in the pending right node, then take the left boundary node.
				ctrl.acc_add = 1'b1;
				if (l_q < r_q) begin
					re_a    = l_q[0];
					raddr_a = l_q[AW-1:0];
					add_a_d = l_q[0];
					l_d     = l_q + NW'(l_q[0]);
					state_d = ST_Q_R;
				end else begin
					add_a_d = 1'b0;
					state_d = ST_RESULT;
				end
			end
			ST_Q_R: begin
				// Fold in the left node, take the right boundary node, go one level up.
				ctrl.acc_add = 1'b1;
				re_a         = r_q[0];
				raddr_a      = r_m[AW-1:0];
				add_a_d      = r_q[0];
				r_d          = r_m >> 1;
				l_d          = l_q >> 1;
				state_d      = ST_Q_L;
			end
			ST_RESULT: begin
				if (!out_valid_q || res_ready) begin
					ctrl.res_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The query window never inverts while it is being walked.
	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_L || state_q == ST_Q_R) |-> (l_q <= r_q))
		else $error("query window inverted");

	// Node zero is unused; only the clearing pass may write it.
	a_no_node_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(we && state_q != ST_CLEAR) |-> (waddr != '0))
		else $error("write to unused node zero");

	// Reads and writes of the node store are never in the same cycle.
	a_rw_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && (re_a || re_b)))
		else $error("node store read and written together");

	// A result shows up only after the sequencer passed through its result state.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RESULT))
		else $error("result raised outside the result state");

endmodule

`default_nettype wire

// ===== src/rsst_acc.sv =====
// Shared 42-bit adder with accumulator, node write data select and result register.
`default_nettype none

module rsst_acc import rsst_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire rsst_ctrl_t              ctrl,
	input  wire logic signed [VAL_W-1:0] set_value,
	input  wire logic [SUM_W-1:0]        rd_a,
	input  wire logic [SUM_W-1:0]        rd_b,
	output logic      [SUM_W-1:0]        wdata,
	output logic signed [SUM_W-1:0]      range_sum
);

	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] range_sum_q;
	logic [SUM_W-1:0] op_x;
	logic [SUM_W-1:0] op_y;
	logic [SUM_W-1:0] sum;

	// One adder: child pair for updates, accumulator plus node for queries.
	always_comb begin
		if (ctrl.acc_add) begin
			op_x = acc_q;
			op_y = ctrl.add_a ? rd_a : '0;
		end else begin
			op_x = rd_a;
			op_y = rd_b;
		end
		sum = op_x + op_y;
	end

	// Node write data.
	always_comb begin
		if (ctrl.wr_zero) begin
			wdata = '0;
		end else if (ctrl.wr_sum) begin
			wdata = sum;
		end else begin
			wdata = acc_q;
		end
	end

	// Accumulator, also holding the new leaf value during an update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.load_val) begin
			acc_q <= {{(SUM_W - VAL_W){set_value[VAL_W-1]}}, set_value};
		end else if (ctrl.clr_acc) begin
			acc_q <= '0;
		end else if (ctrl.acc_add) begin
			acc_q <= sum;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (ctrl.res_load) begin
			range_sum_q <= acc_q;
		end
	end

	assign range_sum = range_sum_q;

endmodule

`default_nettype wire

// ===== src/range_sum_segment_tree_core.sv =====
// Range-sum segment tree: top level joining sequencer, adder datapath and node store.
// The block keeps one 42-bit partial sum per node of a binary tree over LEAVES signed
// 32-bit elements in a single node RAM with one write port and two registered read
// ports. A set (action 0) writes one leaf and recomputes every node on its path to
// the root; it returns nothing, and a set beyond the last element is dropped. A query
// (action 1) returns the wrapped sum of elements range_low..range_high inclusive, with
// range_high clamped to the last element; an empty or reversed range returns 0. One
// operation is in work at a time and the command channel is not ready meanwhile. A set
// reads both children and writes the parent at each level through the shared adder; a
// query reads at most one boundary node on each side per level, between an entry step
// and the result hand-off, and an empty query skips the walk. After reset the block
// first zeroes all 2*LEAVES nodes, one per cycle, and accepts no command until that
// clearing pass is done. A finished query result waits in an output register until
// the result transfer.
`default_nettype none

module range_sum_segment_tree_core import rsst_pkg::*; #(
	parameter int LEAVES = LEAVES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rsst_in_if.sink   cmd,
	rsst_out_if.source res
);

	localparam int AW = $clog2(2 * LEAVES);

	rsst_ctrl_t       ctrl;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [SUM_W-1:0] wdata;
	logic             re_a;
	logic [AW-1:0]    raddr_a;
	logic [SUM_W-1:0] rdata_a;
	logic             re_b;
	logic [AW-1:0]    raddr_b;
	logic [SUM_W-1:0] rdata_b;

	// Sequencer.
	rsst_seq #(
		.LEAVES (LEAVES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res_ready (res.ready),
		.res_valid (res.valid),
		.ctrl      (ctrl),
		.we        (we),
		.waddr     (waddr),
		.re_a      (re_a),
		.raddr_a   (raddr_a),
		.re_b      (re_b),
		.raddr_b   (raddr_b)
	);

	// Shared adder and accumulator.
	rsst_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.set_value (cmd.set_value),
		.rd_a      (rdata_a),
		.rd_b      (rdata_b),
		.wdata     (wdata),
		.range_sum (res.range_sum)
	);

	// Node sum store.
	rsst_ram #(
		.WIDTH (SUM_W),
		.DEPTH (2 * LEAVES)
	) u_nodes (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re_a    (re_a),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.re_b    (re_b),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

endmodule

`default_nettype wire
